// ===== design/hill_cipher_pair_encrypt_assert.svh =====
`ifndef HILL_CIPHER_PAIR_ENCRYPT_ASSERT_SVH
`define HILL_CIPHER_PAIR_ENCRYPT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define HCPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hill cipher block check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define HCPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hill cipher block check failed");

`endif

// ===== design/hcpe_pkg.sv =====
package hcpe_pkg;

  localparam int ALPHA_SIZE = 94;
  localparam int IDX_W      = 7;
  localparam int KEY_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int PROD_W     = KEY_W + IDX_W;
  localparam int SUM_W      = PROD_W + 1;
  // floor(sum / 94) == (sum * RECIP_M) >> RECIP_SH for every sum below 2**SUM_W.
  localparam int RECIP_M    = 44621;
  localparam int RECIP_SH   = 22;
  localparam int RPROD_W    = SUM_W + 16;
  localparam int Q_W        = 8;

  localparam logic [IDX_W-1:0] PAD_INDEX = 7'd23;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 4);

  localparam logic [KEY_W-1:0] KEY_A_RST = 7'd2;
  localparam logic [KEY_W-1:0] KEY_B_RST = 7'd1;
  localparam logic [KEY_W-1:0] KEY_C_RST = 7'd3;
  localparam logic [KEY_W-1:0] KEY_D_RST = 7'd4;

  typedef enum logic [1:0] {
    REG_KEY_A = 2'd0,
    REG_KEY_B = 2'd1,
    REG_KEY_C = 2'd2,
    REG_KEY_D = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ROW_TOP    = 1'b0,
    ROW_BOTTOM = 1'b1
  } row_e;

  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] c;
    logic [KEY_W-1:0] d;
  } keys_t;

  // One unit of work for the back end: a pair to encrypt or an error result.
  typedef struct packed {
    logic             bad;
    logic             last;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] x2;
  } cmd_t;

  typedef struct packed {
    logic             bad;
    logic             last;
    logic [IDX_W-1:0] idx;
  } oq_entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  function automatic lookup_t char_to_index(input logic [CHAR_W-1:0] ch);
    lookup_t r;
    r.found = 1'b1;
    r.idx   = '0;
    case (ch) inside
      [8'h41:8'h5A]: r.idx = IDX_W'(ch - 8'h41);
      [8'h61:8'h7A]: r.idx = IDX_W'(ch - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.idx = IDX_W'(ch - 8'h30 + 8'd52);
      8'h21: r.idx = 7'd62;
      8'h40: r.idx = 7'd63;
      8'h23: r.idx = 7'd64;
      8'h24: r.idx = 7'd65;
      8'h25: r.idx = 7'd66;
      8'h5E: r.idx = 7'd67;
      8'h26: r.idx = 7'd68;
      8'h2A: r.idx = 7'd69;
      8'h28: r.idx = 7'd70;
      8'h29: r.idx = 7'd71;
      8'h5F: r.idx = 7'd72;
      8'h2D: r.idx = 7'd73;
      8'h2B: r.idx = 7'd74;
      8'h3D: r.idx = 7'd75;
      8'h7B: r.idx = 7'd76;
      8'h7D: r.idx = 7'd77;
      8'h5B: r.idx = 7'd78;
      8'h5D: r.idx = 7'd79;
      8'h3C: r.idx = 7'd80;
      8'h3E: r.idx = 7'd81;
      8'h2E: r.idx = 7'd82;
      8'h2C: r.idx = 7'd83;
      8'h3B: r.idx = 7'd84;
      8'h22: r.idx = 7'd85;
      8'h27: r.idx = 7'd86;
      8'h60: r.idx = 7'd87;
      8'h5C: r.idx = 7'd88;
      8'h2F: r.idx = 7'd89;
      8'h3F: r.idx = 7'd90;
      8'h3A: r.idx = 7'd91;
      8'h7E: r.idx = 7'd92;
      8'h20: r.idx = 7'd93;
      default: r.found = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] index_to_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    case (idx) inside
      [7'd0:7'd25]:  c = 8'h41 + CHAR_W'(idx);
      [7'd26:7'd51]: c = 8'h61 + CHAR_W'(idx - 7'd26);
      [7'd52:7'd61]: c = 8'h30 + CHAR_W'(idx - 7'd52);
      7'd62: c = 8'h21;
      7'd63: c = 8'h40;
      7'd64: c = 8'h23;
      7'd65: c = 8'h24;
      7'd66: c = 8'h25;
      7'd67: c = 8'h5E;
      7'd68: c = 8'h26;
      7'd69: c = 8'h2A;
      7'd70: c = 8'h28;
      7'd71: c = 8'h29;
      7'd72: c = 8'h5F;
      7'd73: c = 8'h2D;
      7'd74: c = 8'h2B;
      7'd75: c = 8'h3D;
      7'd76: c = 8'h7B;
      7'd77: c = 8'h7D;
      7'd78: c = 8'h5B;
      7'd79: c = 8'h5D;
      7'd80: c = 8'h3C;
      7'd81: c = 8'h3E;
      7'd82: c = 8'h2E;
      7'd83: c = 8'h2C;
      7'd84: c = 8'h3B;
      7'd85: c = 8'h22;
      7'd86: c = 8'h27;
      7'd87: c = 8'h60;
      7'd88: c = 8'h5C;
      7'd89: c = 8'h2F;
      7'd90: c = 8'h3F;
      7'd91: c = 8'h3A;
      7'd92: c = 8'h7E;
      7'd93: c = 8'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/hcpe_front.sv =====
module hcpe_front
  import hcpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CHAR_W-1:0] plain_char,
  input  logic              end_of_message,
  output logic              cmd_push,
  output cmd_t              cmd
);

  logic [IDX_W-1:0] held_r, held_nxt;
  logic             holding_r, holding_nxt;
  logic             discarding_r, discarding_nxt;
  lookup_t          lk;

  assign lk = char_to_index(plain_char);

  always_comb begin
    held_nxt       = held_r;
    holding_nxt    = holding_r;
    discarding_nxt = discarding_r;
    cmd_push       = 1'b0;
    cmd.bad        = 1'b0;
    cmd.last       = end_of_message;
    cmd.x1         = held_r;
    cmd.x2         = lk.idx;
    if (accept) begin
      if (discarding_r) begin
        if (end_of_message) begin
          discarding_nxt = 1'b0;
        end
      end else if (!lk.found) begin
        // Bad byte: report it, drop any half pair and skip to the message end.
        holding_nxt    = 1'b0;
        held_nxt       = '0;
        discarding_nxt = !end_of_message;
        cmd_push       = 1'b1;
        cmd.bad        = 1'b1;
      end else if (!holding_r) begin
        if (end_of_message) begin
          cmd_push = 1'b1;
          cmd.x1   = lk.idx;
          cmd.x2   = PAD_INDEX;
        end else begin
          held_nxt    = lk.idx;
          holding_nxt = 1'b1;
        end
      end else begin
        holding_nxt = 1'b0;
        cmd_push    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      holding_r    <= 1'b0;
      discarding_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      holding_r    <= holding_nxt;
      discarding_r <= discarding_nxt;
    end
  end

endmodule

// ===== design/hcpe_cmd_queue.sv =====
module hcpe_cmd_queue
  import hcpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/hcpe_back.sv =====
module hcpe_back
  import hcpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  keys_t             keys,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CHAR_W-1:0] out_cipher_char,
  output logic              out_bad_char,
  output logic              out_last_of_message
);

  row_e row_r, row_nxt;

  // Stage 1: the two products of one matrix row.
  logic              v1_r, v1_nxt;
  logic              bad1_r, last1_r;
  logic [PROD_W-1:0] p0_r, p1_r;
  // Stage 2: row sum.
  logic              v2_r;
  logic              bad2_r, last2_r;
  logic [SUM_W-1:0]  sum2_r;
  // Stage 3: quotient by 94.
  logic              v3_r;
  logic              bad3_r, last3_r;
  logic [SUM_W-1:0]  sum3_r;
  logic [Q_W-1:0]    q3_r;

  logic [KEY_W-1:0]   k0, k1;
  logic               issue, last1_nxt;
  logic [RPROD_W-1:0] rprod;
  logic [SUM_W-1:0]   rem;
  oq_entry_t          oq_in;

  oq_entry_t           oq_r [OQ_DEPTH];
  oq_entry_t           oq_head;
  logic [OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt, occupancy;
  logic                oq_pop;

  // Reserve a queue slot for every result still in the pipeline.
  assign occupancy = oq_cnt_r + OQ_CNT_W'(v1_r) + OQ_CNT_W'(v2_r) + OQ_CNT_W'(v3_r);
  assign issue     = !cmd_empty && (occupancy < OQ_CNT_W'(OQ_DEPTH));

  always_comb begin
    row_nxt   = row_r;
    cmd_pop   = 1'b0;
    v1_nxt    = issue;
    last1_nxt = 1'b0;
    if (issue) begin
      if (cmd.bad) begin
        cmd_pop   = 1'b1;
        last1_nxt = cmd.last;
      end else begin
        case (row_r)
          ROW_TOP: begin
            row_nxt = ROW_BOTTOM;
          end
          ROW_BOTTOM: begin
            row_nxt   = ROW_TOP;
            cmd_pop   = 1'b1;
            last1_nxt = cmd.last;
          end
          default: row_nxt = ROW_TOP;
        endcase
      end
    end
  end

  assign k0 = (row_r == ROW_BOTTOM) ? keys.c : keys.a;
  assign k1 = (row_r == ROW_BOTTOM) ? keys.d : keys.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= ROW_TOP;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      row_r <= row_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
    end
  end

  assign rprod = RPROD_W'(sum2_r) * RPROD_W'(RECIP_M);

  always_ff @(posedge clk) begin
    bad1_r  <= cmd.bad;
    last1_r <= last1_nxt;
    p0_r    <= PROD_W'(k0) * PROD_W'(cmd.x1);
    p1_r    <= PROD_W'(k1) * PROD_W'(cmd.x2);
    bad2_r  <= bad1_r;
    last2_r <= last1_r;
    sum2_r  <= SUM_W'(p0_r) + SUM_W'(p1_r);
    bad3_r  <= bad2_r;
    last3_r <= last2_r;
    sum3_r  <= sum2_r;
    q3_r    <= Q_W'(rprod >> RECIP_SH);
  end

  assign rem       = sum3_r - SUM_W'(q3_r) * SUM_W'(ALPHA_SIZE);
  assign oq_in.bad  = bad3_r;
  assign oq_in.last = last3_r;
  assign oq_in.idx  = rem[IDX_W-1:0];

  // Result queue.
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign oq_head   = oq_r[oq_rd_r];
  assign oq_cnt_nxt = oq_cnt_r + OQ_CNT_W'(v3_r) - OQ_CNT_W'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (v3_r) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      oq_r[oq_wr_r] <= oq_in;
    end
  end

  assign out_cipher_char     = oq_head.bad ? '0 : index_to_char(oq_head.idx);
  assign out_bad_char        = oq_head.bad;
  assign out_last_of_message = oq_head.last;

endmodule

// ===== design/hill_cipher_pair_encrypt.sv =====
// Streaming 2x2 Hill cipher over a 94-symbol printable alphabet (A-Z, a-z, 0-9, 31
// punctuation marks and space). Plaintext bytes go in through a queue-style port and
// are taken in pairs; each pair gives two cipher bytes, (a*x1 + b*x2) mod 94 and
// (c*x1 + d*x2) mod 94, with the key weights a..d written through the cfg port
// (reset values 2, 1, 3, 4; write them only while the block is idle). A message of
// odd length is padded with 'X'. A byte outside the alphabet gives one error result
// (cipher 0, bad flag set) and the rest of that message is dropped up to the byte
// that carries end_of_message. Rate: the input side takes one transaction per cycle
// while its 4-entry command queue has room; the back end produces one result per
// cycle through a single multiply and mod-94 pipeline while a command waits and the
// result queue has room, so a message sustains one byte per cycle on average. A
// pair's first result goes through the command queue, pipeline and result queue.
module hill_cipher_pair_encrypt
  import hcpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [CHAR_W-1:0] in_plain_char,
  input  logic              in_end_of_message,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CHAR_W-1:0] out_cipher_char,
  output logic              out_bad_char,
  output logic              out_last_of_message,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [KEY_W-1:0]  cfg_data
);

  keys_t keys_r, keys_nxt;
  logic  accept;
  logic  cmd_push, cmd_pop, cmd_empty;
  cmd_t  cmd_in, cmd_head;

  // Key registers. The index covers exactly the four weights.
  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_KEY_A: keys_nxt.a = cfg_data;
        REG_KEY_B: keys_nxt.b = cfg_data;
        REG_KEY_C: keys_nxt.c = cfg_data;
        REG_KEY_D: keys_nxt.d = cfg_data;
        default:   keys_nxt = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '{a: KEY_A_RST, b: KEY_B_RST, c: KEY_C_RST, d: KEY_D_RST};
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign accept = in_push && !in_full;

  // The front end classifies each byte and tracks pairing and discarding.
  hcpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .plain_char     (in_plain_char),
    .end_of_message (in_end_of_message),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  // Commands wait here so that input and output can stall independently.
  hcpe_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (in_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  // The back end computes and buffers one cipher byte per cycle while fed and with result room.
  hcpe_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .keys                (keys_r),
    .cmd_empty           (cmd_empty),
    .cmd                 (cmd_head),
    .cmd_pop             (cmd_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_cipher_char     (out_cipher_char),
    .out_bad_char        (out_bad_char),
    .out_last_of_message (out_last_of_message)
  );

endmodule

// ===== design/hcpe_checker.sv =====
`include "hill_cipher_pair_encrypt_assert.svh"

module hcpe_checker
  import hcpe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [CHAR_W-1:0] out_cipher_char,
  input logic              out_bad_char,
  input logic              out_last_of_message
);

  logic              res_shown;
  logic              res_printable;
  logic [CHAR_W+1:0] res_bits;

  assign res_shown     = !out_empty;
  assign res_printable = (out_cipher_char >= 8'h20) && (out_cipher_char <= 8'h7E);
  assign res_bits      = {out_cipher_char, out_bad_char, out_last_of_message};

  // An error result always carries a zero cipher byte.
  `HCPE_ASSERT_NOW(a_bad_is_zero, res_shown && out_bad_char, out_cipher_char == '0)

  // A good result is always a printable alphabet symbol.
  `HCPE_ASSERT_NOW(a_good_printable, res_shown && !out_bad_char, res_printable)

  // A waiting result that is not taken stays on the ports unchanged.
  `HCPE_ASSERT_NEXT(a_hold_result, res_shown && !out_pop, res_shown && $stable(res_bits))

endmodule

bind hill_cipher_pair_encrypt hcpe_checker u_hcpe_checker (.*);
